@@ hdl/ket_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyed entry table package
// Shared request, response and entry types, operation and status codes.
// ----------------------------------------------------------------------------
package ket_pkg;

   localparam int DEFAULT_ENTRIES = 32;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_SET    = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [30:0]        device_id;
      logic [7:0]         unit_kind;
      logic [7:0]         unit_index;
      logic signed [31:0] new_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] found_value;
   } rsp_type;

   typedef struct packed {
      logic [30:0]        device_id;
      logic [7:0]         unit_kind;
      logic [7:0]         unit_index;
      logic signed [31:0] value;
   } entry_type;

endpackage

@@ hdl/keyed_entry_table.sv @@
// ----------------------------------------------------------------------------
// Keyed entry table
// Associative table keyed by device id, unit type and unit number, scanned
// entry by entry with a single comparator for lookup, set/insert and delete.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// while the table is scanned and until the one-cycle rsp_strobe. The scan
// reads one entry per cycle through the single read port of the entry
// memory and feeds one key comparator, and the last cycle performs the write
// and registers the response. The response cannot be held off, so it must be
// captured in the cycle rsp_strobe is high. The table is empty after reset;
// per-entry valid bits cleared by reset make this immediate.
module keyed_entry_table #(
   parameter int ENTRIES = ket_pkg::DEFAULT_ENTRIES
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ket_pkg::req_type req_data,
   output logic            rsp_strobe,
   output ket_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   ket_pkg::entry_type mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic [1:0]          state_ff, state_in;
   ket_pkg::req_type    req_ff, req_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   ket_pkg::entry_type  rd_data_ff;
   logic                rd_live_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                rd_go_ff, rd_go_in;
   logic                hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic signed [31:0]  hit_value_ff, hit_value_in;
   logic                free_found_ff, free_found_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   ket_pkg::rsp_type    rsp_ff, rsp_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   ket_pkg::entry_type  wr_entry;
   ket_pkg::entry_type  cmp_entry;
   logic                key_match;
   logic                entry_free;
   logic                scan_end;

   assign scan_end = (scan_ff == CNT_W'(ENTRIES));

   // An entry that is not valid reads as all zero, as after reset.
   always_comb begin
      cmp_entry  = rd_live_ff ? rd_data_ff : '0;
      key_match  = (cmp_entry.device_id == req_ff.device_id) &&
                   (cmp_entry.unit_kind == req_ff.unit_kind) &&
                   (cmp_entry.unit_index == req_ff.unit_index);
      entry_free = (cmp_entry.device_id == '0);
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_in       = scan_ff;
      rd_go_in      = 1'b0;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_value_in  = hit_value_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      valid_in      = valid_ff;
      wr_en         = 1'b0;
      wr_idx        = hit_idx_ff;
      wr_entry      = '0;

      // First matching and first free entries are kept as the scan goes by.
      if (rd_go_ff) begin
         if (key_match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = rd_idx_ff;
            hit_value_in = cmp_entry.value;
         end
         if (entry_free && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in        = req_data;
               scan_in       = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!scan_end) begin
               scan_in  = scan_ff + CNT_W'(1);
               rd_go_in = 1'b1;
            end else if (!rd_go_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_in.status      = ket_pkg::STATUS_NOT_FOUND;
            rsp_in.found_value = '0;
            wr_entry.device_id  = req_ff.device_id;
            wr_entry.unit_kind  = req_ff.unit_kind;
            wr_entry.unit_index = req_ff.unit_index;
            wr_entry.value      = req_ff.new_value;
            case (req_ff.mode)
               ket_pkg::MODE_LOOKUP: begin
                  if (hit_found_ff) begin
                     rsp_in.status      = ket_pkg::STATUS_OK;
                     rsp_in.found_value = hit_value_ff;
                  end
               end
               ket_pkg::MODE_SET: begin
                  if (hit_found_ff) begin
                     wr_en         = 1'b1;
                     rsp_in.status = ket_pkg::STATUS_OK;
                  end else if (free_found_ff) begin
                     wr_en         = 1'b1;
                     wr_idx        = free_idx_ff;
                     rsp_in.status = ket_pkg::STATUS_OK;
                  end else begin
                     rsp_in.status = ket_pkg::STATUS_FULL;
                  end
                  if (wr_en) begin
                     valid_in[wr_idx] = 1'b1;
                  end
               end
               ket_pkg::MODE_DELETE: begin
                  // Clearing the valid bit makes the entry read as all zero.
                  if (hit_found_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     rsp_in.status        = ket_pkg::STATUS_OK;
                  end
               end
               default: begin
                  rsp_in.status = ket_pkg::STATUS_NOT_FOUND;
               end
            endcase
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      rd_data_ff <= mem[scan_ff[IDX_W-1:0]];
      rd_live_ff <= valid_ff[scan_ff[IDX_W-1:0]];
      rd_idx_ff  <= scan_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rd_go_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         scan_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rd_go_ff      <= rd_go_in;
         rsp_strobe_ff <= rsp_strobe_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         scan_ff       <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      hit_idx_ff   <= hit_idx_in;
      hit_value_ff <= hit_value_in;
      free_idx_ff  <= free_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response issued while still busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ket_pkg::STATUS_OK) |->
      (rsp_data.found_value == '0))
      else $error("nonzero value on a failed request");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      rd_go_ff |-> (state_ff == S_SCAN))
      else $error("entry compare outside of the scan");

endmodule
